// ===== sv/dimp_pkg.sv =====
// ----------------------------------------------------------------------------
// dimp_pkg
// Shared types, character codes and the byte classifier of the delimited
// integer matrix parser.
// ----------------------------------------------------------------------------
package dimp_pkg;

  // Parse phase of the current field, one-hot.
  typedef enum logic [3:0] {
    PH_START   = 4'b0001,
    PH_SIGN    = 4'b0010,
    PH_DIGITS  = 4'b0100,
    PH_STOPPED = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    CLS_TEXT,
    CLS_DELIM,
    CLS_SKIP
  } class_e;

  // One step of work for the field and index units.
  typedef struct packed {
    logic flush;
    logic delim;
    logic take;
  } step_t;

  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;
  localparam logic [7:0] CHAR_BAR    = 8'h7C;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_VT     = 8'h0B;
  localparam logic [7:0] CHAR_FF     = 8'h0C;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;

  localparam logic [15:0] ROW_WIDTH_RESET = 16'd1;

  function automatic class_e classify(logic [7:0] c);
    class_e cls;
    unique case (c) inside
      CHAR_COMMA, CHAR_SEMI, CHAR_BAR, CHAR_SPACE, CHAR_TAB, CHAR_LF: cls = CLS_DELIM;
      CHAR_DQUOTE, CHAR_SQUOTE, CHAR_CR:                             cls = CLS_SKIP;
      default:                                                       cls = CLS_TEXT;
    endcase
    return cls;
  endfunction

endpackage

// ===== sv/dimp_field.sv =====
// ----------------------------------------------------------------------------
// dimp_field
// Field accumulator: sign, phase and saturating decimal magnitude of the
// field being parsed, and the signed value it stands for.
// ----------------------------------------------------------------------------
module dimp_field (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dimp_pkg::step_t    step_i,
  input  logic [7:0]         text_byte_i,
  output logic               pending_o,
  output logic signed [31:0] value_o
);

  dimp_pkg::phase_e phase_q, phase_d;
  logic [31:0]      mag_q, mag_d;
  logic             neg_q, neg_d;
  logic             pend_q, pend_d;

  logic             is_digit;
  logic [3:0]       digit;
  logic [35:0]      mag_x10;
  logic [35:0]      acc;
  logic [31:0]      acc_mag;
  dimp_pkg::phase_e acc_phase;

  assign is_digit = (text_byte_i >= dimp_pkg::CHAR_ZERO) &&
                    (text_byte_i <= dimp_pkg::CHAR_NINE);
  assign digit    = 4'(text_byte_i - dimp_pkg::CHAR_ZERO);

  // Times ten as two shifts; the magnitude never exceeds 2^31.
  assign mag_x10 = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1);
  assign acc     = mag_x10 + {32'b0, digit};
  assign acc_mag = (acc > {4'b0, dimp_pkg::MAG_LIMIT}) ? dimp_pkg::MAG_LIMIT : acc[31:0];

  // A non-digit stops the number for good; the field still counts as present.
  assign acc_phase = is_digit ? dimp_pkg::PH_DIGITS : dimp_pkg::PH_STOPPED;

  always_comb begin
    phase_d = phase_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    pend_d  = pend_q;
    if (step_i.flush || step_i.delim) begin
      phase_d = dimp_pkg::PH_START;
      mag_d   = '0;
      neg_d   = 1'b0;
      pend_d  = 1'b0;
    end else if (step_i.take) begin
      pend_d = 1'b1;
      unique case (phase_q)
        dimp_pkg::PH_START: begin
          if ((text_byte_i == dimp_pkg::CHAR_VT) || (text_byte_i == dimp_pkg::CHAR_FF)) begin
            phase_d = dimp_pkg::PH_START;
          end else if ((text_byte_i == dimp_pkg::CHAR_PLUS) ||
                       (text_byte_i == dimp_pkg::CHAR_MINUS)) begin
            neg_d   = (text_byte_i == dimp_pkg::CHAR_MINUS);
            phase_d = dimp_pkg::PH_SIGN;
          end else begin
            phase_d = acc_phase;
            if (is_digit) mag_d = acc_mag;
          end
        end
        dimp_pkg::PH_SIGN, dimp_pkg::PH_DIGITS: begin
          phase_d = acc_phase;
          if (is_digit) mag_d = acc_mag;
        end
        dimp_pkg::PH_STOPPED: begin
          phase_d = dimp_pkg::PH_STOPPED;
        end
        default: begin
          phase_d = dimp_pkg::PH_STOPPED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dimp_pkg::PH_START;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      pend_q  <= pend_d;
    end
  end

  // Negation wraps, so a saturated negative field gives the most negative value.
  assign value_o   = neg_q ? $signed(32'(32'd0 - mag_q))
                           : $signed((mag_q > dimp_pkg::VALUE_MAX) ? dimp_pkg::VALUE_MAX : mag_q);
  assign pending_o = pend_q;

endmodule

// ===== sv/dimp_index.sv =====
// ----------------------------------------------------------------------------
// dimp_index
// Row and column counters. The column wraps at the effective row width and
// the row saturates at the largest index the counters hold.
// ----------------------------------------------------------------------------
module dimp_index #(
  parameter int unsigned CNT_W = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dimp_pkg::step_t step_i,
  input  logic [15:0]     row_width_i,
  output logic [15:0]     row_o,
  output logic [15:0]     column_o,
  output logic            col_nonzero_o
);

  localparam logic [16:0] WidthLimit = 17'd1 << CNT_W;

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [CNT_W:0]   col_inc;
  logic [16:0]      width_full;
  logic [CNT_W:0]   width_eff;

  // A width of zero acts as one; a width beyond the counter range is clamped.
  always_comb begin
    if (row_width_i == 16'd0) begin
      width_full = 17'd1;
    end else if ({1'b0, row_width_i} > WidthLimit) begin
      width_full = WidthLimit;
    end else begin
      width_full = {1'b0, row_width_i};
    end
  end

  assign width_eff = width_full[CNT_W:0];
  assign col_inc   = {1'b0, col_q} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step_i.flush) begin
      col_d = '0;
      row_d = '0;
    end else if (step_i.delim) begin
      if (col_inc >= width_eff) begin
        col_d = '0;
        if (row_q != {CNT_W{1'b1}}) row_d = row_q + {{(CNT_W-1){1'b0}}, 1'b1};
      end else begin
        col_d = col_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign row_o         = 16'(row_q);
  assign column_o      = 16'(col_q);
  assign col_nonzero_o = (col_q != '0);

endmodule

// ===== sv/delimited_integer_matrix_parser.sv =====
// ----------------------------------------------------------------------------
// delimited_integer_matrix_parser
// Parses signed decimal integers from a byte stream and tags each value with
// its matrix row and column.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o   kind_i, text_byte_i
//   out      output     out_valid_o / out_ready_i row_o, column_o, value_o
//   cfg      input      cfg_we_i                  cfg_data_i (row width)
//
// One byte per cycle: a byte sits in the input register while the field and
// index state update and any value goes to the result register. Bytes that
// give no value never wait on the output side. A byte that gives a value
// waits only while the result register holds an untaken value.
// Reset clears both registers' valid flags, the field state, the counters,
// and sets the row width to one.
// ----------------------------------------------------------------------------
module delimited_integer_matrix_parser #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [7:0]         text_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        row_o,
  output logic [15:0]        column_o,
  output logic signed [31:0] value_o
);

  localparam int unsigned CntW = (INDEX_BITS < 16) ? INDEX_BITS : 16;

  logic [15:0]        row_width_q;
  logic               inq_valid_q;
  logic               inq_kind_q;
  logic [7:0]         inq_byte_q;
  logic               out_valid_q;
  logic [15:0]        out_row_q;
  logic [15:0]        out_col_q;
  logic signed [31:0] out_value_q;

  dimp_pkg::class_e   cls;
  dimp_pkg::step_t    step;
  logic               emit;
  logic               out_free;
  logic               advance;
  logic               in_xfer;
  logic               pending;
  logic signed [31:0] field_value;
  logic [15:0]        cur_row;
  logic [15:0]        cur_col;
  logic               col_nonzero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= dimp_pkg::ROW_WIDTH_RESET;
    end else if (cfg_we_i) begin
      row_width_q <= cfg_data_i;
    end
  end

  assign cls = dimp_pkg::classify(inq_byte_q);

  // End of stream gives a value only for a started field past column zero.
  assign emit = inq_valid_q &&
                (inq_kind_q ? (pending && col_nonzero) : (cls == dimp_pkg::CLS_DELIM));

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = inq_valid_q && (!emit || out_free);
  assign in_ready_o = !inq_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign step.flush = advance && inq_kind_q;
  assign step.delim = advance && !inq_kind_q && (cls == dimp_pkg::CLS_DELIM);
  assign step.take  = advance && !inq_kind_q && (cls == dimp_pkg::CLS_TEXT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      inq_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      inq_kind_q <= kind_i;
      inq_byte_q <= text_byte_i;
    end
  end

  dimp_field u_field (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .text_byte_i (inq_byte_q),
    .pending_o   (pending),
    .value_o     (field_value)
  );

  dimp_index #(
    .CNT_W (CntW)
  ) u_index (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .row_width_i   (row_width_q),
    .row_o         (cur_row),
    .column_o      (cur_col),
    .col_nonzero_o (col_nonzero)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !out_ready_i) || (advance && emit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_row_q   <= cur_row;
      out_col_q   <= cur_col;
      out_value_q <= field_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_o       = out_row_q;
  assign column_o    = out_col_q;
  assign value_o     = out_value_q;

endmodule

// ===== sv/dimp_checker.sv =====
// ----------------------------------------------------------------------------
// dimp_checker
// Port-level checks of the delimited integer matrix parser, bound to the top
// level.
// ----------------------------------------------------------------------------
module dimp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               kind_i,
  input logic [7:0]         text_byte_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [15:0]        row_o,
  input logic [15:0]        column_o,
  input logic signed [31:0] value_o
);

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(row_o) && $stable(column_o) && $stable(value_o))
    else $error("result changed while stalled");

  // A stalled input transfer keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(kind_i) && $stable(text_byte_i))
    else $error("input changed while stalled");

  // The input side only stalls behind an untaken result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // A valid result carries a fully known payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown({row_o, column_o, value_o}))
    else $error("unknown bits in a valid result");

  // Reset leaves no result behind.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind delimited_integer_matrix_parser dimp_checker u_dimp_checker (.*);

// ===== tb/tb_delimited_integer_matrix_parser.sv =====
// ----------------------------------------------------------------------------
// tb_delimited_integer_matrix_parser
// Self-checking testbench for the delimited integer matrix parser. A driver
// feeds text bytes and end-of-stream markers from a backlog, a predictor
// computes each expected (row, column, value) entry, and a monitor compares
// every output transfer with the oldest prediction. Runs cover directed
// corner cases and random CSV-like streams at several row widths.
// ----------------------------------------------------------------------------
module tb_delimited_integer_matrix_parser;

  localparam int unsigned INDEX_BITS    = 16;
  localparam logic [15:0] ROW_LAST      = (INDEX_BITS >= 16) ? 16'hFFFF :
                                          16'((1 << INDEX_BITS) - 1);
  localparam int unsigned IDLE_PCT      = 11;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam logic        KIND_TEXT     = 1'b0;
  localparam logic        KIND_FLUSH    = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] text;
  } stream_item_t;

  typedef struct packed {
    logic [15:0]        row;
    logic [15:0]        column;
    logic signed [31:0] value;
  } matrix_entry_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [15:0]        cfg_data_i  = 16'd0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               kind_i      = KIND_TEXT;
  logic [7:0]         text_byte_i = 8'd0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        row_o;
  logic [15:0]        column_o;
  logic signed [31:0] value_o;

  delimited_integer_matrix_parser #(
    .INDEX_BITS(INDEX_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .text_byte_i(text_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .row_o      (row_o),
    .column_o   (column_o),
    .value_o    (value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stream_item_t  byte_backlog[$];
  matrix_entry_t awaited_entries[$];
  bit            calm = 1'b0;
  int unsigned   error_count = 0;
  int unsigned   bytes_taken = 0;
  int unsigned   flushes_taken = 0;
  int unsigned   entries_checked = 0;
  int unsigned   quiet_cycles = 0;

  // Shadow copy of the parser state.
  logic [15:0]      row_width_q;
  logic [15:0]      column_count;
  logic [15:0]      row_count;
  logic [31:0]      magnitude;
  logic             field_negative;
  dimp_pkg::phase_e field_phase;
  logic             field_pending;

  task automatic clear_field();
    magnitude      = 32'd0;
    field_negative = 1'b0;
    field_phase    = dimp_pkg::PH_START;
    field_pending  = 1'b0;
  endtask

  function automatic matrix_entry_t current_entry();
    matrix_entry_t e;
    e.row    = row_count;
    e.column = column_count;
    if (field_negative) e.value = 32'd0 - magnitude;
    else if (magnitude > dimp_pkg::VALUE_MAX) e.value = dimp_pkg::VALUE_MAX;
    else e.value = magnitude;
    return e;
  endfunction

  task automatic accumulate_char(logic [7:0] c);
    logic [63:0] grown;
    field_pending = 1'b1;
    if (field_phase == dimp_pkg::PH_START) begin
      if (c == dimp_pkg::CHAR_VT || c == dimp_pkg::CHAR_FF) return;
      if (c == dimp_pkg::CHAR_PLUS || c == dimp_pkg::CHAR_MINUS) begin
        field_negative = (c == dimp_pkg::CHAR_MINUS);
        field_phase    = dimp_pkg::PH_SIGN;
        return;
      end
    end
    if (field_phase == dimp_pkg::PH_STOPPED) return;
    if (c >= dimp_pkg::CHAR_ZERO && c <= dimp_pkg::CHAR_NINE) begin
      grown = {32'd0, magnitude} * 64'd10 + 64'(c - dimp_pkg::CHAR_ZERO);
      if (grown > 64'(dimp_pkg::MAG_LIMIT)) grown = 64'(dimp_pkg::MAG_LIMIT);
      magnitude   = grown[31:0];
      field_phase = dimp_pkg::PH_DIGITS;
    end else begin
      field_phase = dimp_pkg::PH_STOPPED;
    end
  endtask

  task automatic predict_transfer(logic kind, logic [7:0] c);
    int unsigned span;
    span = (row_width_q == 16'd0) ? 1 : int'(row_width_q);
    if (kind == KIND_FLUSH) begin
      if (field_pending && column_count != 16'd0) awaited_entries.push_back(current_entry());
      clear_field();
      column_count = 16'd0;
      row_count    = 16'd0;
    end else begin
      case (c)
        dimp_pkg::CHAR_COMMA, dimp_pkg::CHAR_SEMI, dimp_pkg::CHAR_BAR,
        dimp_pkg::CHAR_SPACE, dimp_pkg::CHAR_TAB, dimp_pkg::CHAR_LF: begin
          awaited_entries.push_back(current_entry());
          clear_field();
          if (int'(column_count) + 1 >= span) begin
            column_count = 16'd0;
            if (row_count != ROW_LAST) row_count = row_count + 16'd1;
          end else begin
            column_count = column_count + 16'd1;
          end
        end
        dimp_pkg::CHAR_DQUOTE, dimp_pkg::CHAR_SQUOTE, dimp_pkg::CHAR_CR: ;
        default: accumulate_char(c);
      endcase
    end
  endtask

  // Driver: valid holds with a stable payload until the transfer happens.
  always @(posedge clk_i) begin
    stream_item_t next_item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_transfer(kind_i, text_byte_i);
        bytes_taken++;
        if (kind_i == KIND_FLUSH) flushes_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (byte_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          next_item   = byte_backlog.pop_front();
          in_valid_i  <= 1'b1;
          kind_i      <= next_item.kind;
          text_byte_i <= next_item.text;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: each output transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    matrix_entry_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_entries.size() == 0) begin
        $error("unexpected result: row %0d, column %0d, value %0d", row_o, column_o, value_o);
        error_count++;
      end else begin
        want = awaited_entries.pop_front();
        entries_checked++;
        if (row_o !== want.row) begin
          $error("row: expected %0d, actual %0d", want.row, row_o);
          error_count++;
        end
        if (column_o !== want.column) begin
          $error("column: expected %0d, actual %0d", want.column, column_o);
          error_count++;
        end
        if (value_o !== want.value) begin
          $error("value: expected %0d, actual %0d", want.value, value_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push_byte(logic [7:0] c);
    byte_backlog.push_back('{kind: KIND_TEXT, text: c});
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // The byte that rides along with an end-of-stream marker is random.
  task automatic push_flush();
    byte_backlog.push_back('{kind: KIND_FLUSH, text: 8'($urandom_range(255))});
  endtask

  function automatic logic [7:0] pick_delimiter();
    case ($urandom_range(5))
      0: return dimp_pkg::CHAR_COMMA;
      1: return dimp_pkg::CHAR_SEMI;
      2: return dimp_pkg::CHAR_BAR;
      3: return dimp_pkg::CHAR_SPACE;
      4: return dimp_pkg::CHAR_TAB;
      default: return dimp_pkg::CHAR_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_ignored();
    case ($urandom_range(2))
      0: return dimp_pkg::CHAR_DQUOTE;
      1: return dimp_pkg::CHAR_SQUOTE;
      default: return dimp_pkg::CHAR_CR;
    endcase
  endfunction

  task automatic add_digits(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 5) push_byte(pick_ignored());
      push_byte(dimp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
    end
  endtask

  // Mostly well-formed numbers; the rest are empty, junk-tailed or raw noise.
  task automatic add_random_field();
    int unsigned pick;
    if ($urandom_range(99) < 8) begin
      push_byte($urandom_range(1) ? dimp_pkg::CHAR_VT : dimp_pkg::CHAR_FF);
    end
    pick = $urandom_range(99);
    if (pick < 52) begin
      case ($urandom_range(2))
        1: push_byte(dimp_pkg::CHAR_PLUS);
        2: push_byte(dimp_pkg::CHAR_MINUS);
        default: ;
      endcase
      add_digits(($urandom_range(99) < 12) ? $urandom_range(10, 13) : $urandom_range(1, 6));
    end else if (pick < 62) begin
      // Empty field.
    end else if (pick < 74) begin
      add_digits($urandom_range(1, 4));
      push_byte(8'($urandom_range(8'h61, 8'h7A)));
      add_digits($urandom_range(0, 3));
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
    end else begin
      push_byte($urandom_range(1) ? dimp_pkg::CHAR_PLUS : dimp_pkg::CHAR_MINUS);
      case ($urandom_range(2))
        0: push_byte(dimp_pkg::CHAR_PLUS);
        1: push_byte(dimp_pkg::CHAR_MINUS);
        default: add_digits(1);
      endcase
    end
    if ($urandom_range(99) < 5) push_flush();
    else push_byte(pick_delimiter());
  endtask

  task automatic add_random_stream(int unsigned count);
    int unsigned target;
    target = byte_backlog.size() + count;
    while (byte_backlog.size() < target) add_random_field();
  endtask

  // Returns once the backlog is sent and every predicted entry has arrived.
  task automatic wait_drained();
    while (byte_backlog.size() != 0 || in_valid_i || awaited_entries.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_row_width(logic [15:0] width);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= width;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    row_width_q = width;
  endtask

  initial begin
    row_width_q  = dimp_pkg::ROW_WIDTH_RESET;
    column_count = 16'd0;
    row_count    = 16'd0;
    clear_field();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_row_width(16'd3);
    push_text("-9999999999;");        // negative magnitude saturates
    push_byte(dimp_pkg::CHAR_DQUOTE);
    push_text("7");
    push_byte(dimp_pkg::CHAR_CR);
    push_byte(dimp_pkg::CHAR_SQUOTE);
    push_byte(dimp_pkg::CHAR_BAR);
    push_byte(dimp_pkg::CHAR_VT);     // skipped before the sign
    push_text("+x");
    push_byte(dimp_pkg::CHAR_TAB);    // row wraps here
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(dimp_pkg::CHAR_SPACE);
    push_byte(dimp_pkg::CHAR_LF);
    push_text("5");
    push_flush();                     // pending field at a nonzero column
    push_flush();                     // nothing pending
    push_text("3");
    push_flush();                     // pending field at column zero
    wait_drained();

    // A zero width behaves as one. The sender stops halfway until all is out.
    write_row_width(16'd0);
    add_random_stream(70);
    wait_drained();
    add_random_stream(70);
    wait_drained();

    calm = 1'b1;
    write_row_width(16'hFFFF);
    add_random_stream(160);
    wait_drained();
    calm = 1'b0;

    write_row_width(16'($urandom_range(2, 7)));
    add_random_stream(100);
    wait_drained();
    write_row_width(16'($urandom_range(2, 7)));
    add_random_stream(100);
    wait_drained();

    // Single-value rows, closed by an end-of-stream marker.
    write_row_width(16'd1);
    add_random_stream(20);
    push_flush();
    wait_drained();

    if (awaited_entries.size() != 0) begin
      $error("%0d predicted entries never arrived", awaited_entries.size());
      error_count++;
    end
    $display("Checked %0d parsed values from %0d input transfers, %0d of them end-of-stream.",
             entries_checked, bytes_taken, flushes_taken);
    $display("Row widths covered: 0, 1, 3, 65535 and random small widths.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
